// File: hw/rtl/datagram_deframe_check_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the datagram deframer
// Shared concurrent property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DATAGRAM_DEFRAME_CHECK_MACROS_SVH
`define DATAGRAM_DEFRAME_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// File: hw/rtl/ddc_pkg.sv
// ----------------------------------------------------------------------------
// ddc_pkg
// Shared types and constants for the datagram deframer and checker.
// ----------------------------------------------------------------------------
package ddc_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 512;
    localparam int DEF_KEY_MAX_BYTES   = 16;

    // Configuration port geometry: four 64-bit registers at 8-byte strides.
    localparam int DATA_W       = 64;
    localparam int ADDR_W       = 5;
    localparam int REG_ADDR_LSB = 3;
    localparam int KEY_LEN_W    = 5;

    typedef enum logic [1:0] {
        REG_MAGIC      = 2'd0,
        REG_KEY_LOW    = 2'd1,
        REG_KEY_HIGH   = 2'd2,
        REG_KEY_LENGTH = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_KEEPALIVE    = 3'd1,
        ST_SHORT_HEADER = 3'd2,
        ST_TOO_LONG     = 3'd3,
        ST_BAD_MAGIC    = 3'd4,
        ST_SHORT_SUM    = 3'd5,
        ST_SUM_MISMATCH = 3'd6
    } status_t;

    typedef struct packed {
        logic [15:0]          magic_word;
        logic [63:0]          key_bytes_high;
        logic [63:0]          key_bytes_low;
        logic [KEY_LEN_W-1:0] key_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_end;
        status_t    frame_status;
    } res_t;

endpackage

// File: hw/rtl/ddc_stream_if.sv
// ----------------------------------------------------------------------------
// ddc_rx_if / ddc_res_if
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface ddc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, output rx_byte, output rx_last, input ready);
    modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

interface ddc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_end;
    logic [2:0] frame_status;

    modport source (
        output valid, output payload_byte, output payload_valid,
        output frame_end, output frame_status, input ready
    );
    modport sink (
        input valid, input payload_byte, input payload_valid,
        input frame_end, input frame_status, output ready
    );
endinterface

// File: hw/rtl/ddc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ddc_cfg_regs
// APB-style register file holding the magic word and the XOR key.
// ----------------------------------------------------------------------------
module ddc_cfg_regs
    import ddc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:REG_ADDR_LSB]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MAGIC:      cfg_reg.magic_word     <= pwdata[15:0];
                REG_KEY_LOW:    cfg_reg.key_bytes_low  <= pwdata;
                REG_KEY_HIGH:   cfg_reg.key_bytes_high <= pwdata;
                REG_KEY_LENGTH: cfg_reg.key_length     <= pwdata[KEY_LEN_W-1:0];
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAGIC:      prdata = {48'd0, cfg_reg.magic_word};
            REG_KEY_LOW:    prdata = cfg_reg.key_bytes_low;
            REG_KEY_HIGH:   prdata = cfg_reg.key_bytes_high;
            REG_KEY_LENGTH: prdata = {{(DATA_W-KEY_LEN_W){1'b0}}, cfg_reg.key_length};
            default:        prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/ddc_frame_engine.sv
// ----------------------------------------------------------------------------
// ddc_frame_engine
// Per-frame state: magic check, key XOR, checksum capture and Fletcher-16.
// ----------------------------------------------------------------------------
module ddc_frame_engine
    import ddc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int KEY_MAX_BYTES   = DEF_KEY_MAX_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       beat_fire,
    input  logic [7:0] rx_byte,
    input  logic       rx_last,
    output res_t       res,
    output logic       has_result
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int KP_W  = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam logic [POS_W-1:0]     POS_LIMIT = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0]     POS_SAT   = POS_W'(MAX_FRAME_BYTES + 1);
    localparam logic [KEY_LEN_W-1:0] KLEN_CAP  = KEY_LEN_W'(KEY_MAX_BYTES);

    logic [POS_W-1:0] pos_reg,        pos_next;
    logic [KP_W-1:0]  key_pos_reg,    key_pos_next;
    logic [7:0]       magic_high_reg, magic_high_next;
    logic             magic_good_reg, magic_good_next;
    logic [15:0]      recv_sum_reg,   recv_sum_next;
    logic [7:0]       sum_one_reg,    sum_one_next;
    logic [7:0]       sum_two_reg,    sum_two_next;

    logic [KEY_LEN_W-1:0] klen;
    logic [KEY_LEN_W-1:0] key_pos_inc;
    logic [127:0]         key_vec;
    logic [7:0]           key_byte;
    logic [7:0]           plain;

    // Add modulo 255 for operands already below 255.
    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 9'd255) ? 8'(s - 9'd255) : s[7:0];
    endfunction

    assign klen        = (cfg.key_length > KLEN_CAP) ? KLEN_CAP : cfg.key_length;
    assign key_pos_inc = KEY_LEN_W'(key_pos_reg) + 1'b1;
    assign key_vec     = {cfg.key_bytes_high, cfg.key_bytes_low};
    assign key_byte    = key_vec[{4'(key_pos_reg), 3'b000} +: 8];
    assign plain       = (klen != '0) ? (rx_byte ^ key_byte) : rx_byte;

    always_comb
    begin
        pos_next        = pos_reg;
        key_pos_next    = key_pos_reg;
        magic_high_next = magic_high_reg;
        magic_good_next = magic_good_reg;
        recv_sum_next   = recv_sum_reg;
        sum_one_next    = sum_one_reg;
        sum_two_next    = sum_two_reg;
        res             = '{payload_byte: 8'd0, payload_valid: 1'b0,
                            frame_end: 1'b0, frame_status: ST_OK};

        if (beat_fire)
        begin
            pos_next = (pos_reg == POS_SAT) ? pos_reg : pos_reg + 1'b1;

            if (pos_reg == POS_W'(0))
            begin
                magic_high_next = rx_byte;
            end
            else if (pos_reg == POS_W'(1))
            begin
                magic_good_next = ({magic_high_reg, rx_byte} == cfg.magic_word);
            end
            else if (pos_reg < POS_LIMIT)
            begin
                if (klen != '0)
                begin
                    key_pos_next = (key_pos_inc >= klen) ? '0 : KP_W'(key_pos_inc);
                end
                if (pos_reg == POS_W'(2))
                begin
                    recv_sum_next[15:8] = plain;
                end
                else if (pos_reg == POS_W'(3))
                begin
                    recv_sum_next[7:0] = plain;
                end
                else if (magic_good_reg)
                begin
                    sum_one_next      = add_mod255(sum_one_reg, plain);
                    sum_two_next      = add_mod255(sum_two_reg, sum_one_next);
                    res.payload_valid = 1'b1;
                    res.payload_byte  = plain;
                end
            end

            if (rx_last)
            begin
                res.frame_end = 1'b1;
                if (pos_reg == POS_W'(0))
                    res.frame_status = ST_SHORT_HEADER;
                else if (pos_reg >= POS_LIMIT)
                    res.frame_status = ST_TOO_LONG;
                else if (!magic_good_next)
                    res.frame_status = ST_BAD_MAGIC;
                else if (pos_reg == POS_W'(1))
                    res.frame_status = ST_KEEPALIVE;
                else if (pos_reg == POS_W'(2))
                    res.frame_status = ST_SHORT_SUM;
                else if ({sum_two_next, sum_one_next} != recv_sum_next)
                    res.frame_status = ST_SUM_MISMATCH;
                else
                    res.frame_status = ST_OK;

                pos_next        = '0;
                key_pos_next    = '0;
                magic_high_next = '0;
                magic_good_next = 1'b0;
                recv_sum_next   = '0;
                sum_one_next    = '0;
                sum_two_next    = '0;
            end
        end
    end

    assign has_result = beat_fire && (res.payload_valid || rx_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            key_pos_reg    <= '0;
            magic_high_reg <= '0;
            magic_good_reg <= 1'b0;
            recv_sum_reg   <= '0;
            sum_one_reg    <= '0;
            sum_two_reg    <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            key_pos_reg    <= key_pos_next;
            magic_high_reg <= magic_high_next;
            magic_good_reg <= magic_good_next;
            recv_sum_reg   <= recv_sum_next;
            sum_one_reg    <= sum_one_next;
            sum_two_reg    <= sum_two_next;
        end
    end

endmodule

// File: hw/rtl/ddc_out_reg.sv
// ----------------------------------------------------------------------------
// ddc_out_reg
// Result register between the frame engine and the result channel.
// ----------------------------------------------------------------------------
module ddc_out_reg
    import ddc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res_in,
    input  logic out_ready,
    output logic out_valid,
    output res_t res_out,
    output logic in_ready
);

    logic valid_reg, valid_next;
    res_t res_reg;

    // A new beat may enter when no result is held or the held result leaves in the same cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

endmodule

// File: hw/rtl/datagram_deframe_check.sv
// ----------------------------------------------------------------------------
// datagram_deframe_check: one received byte per beat; each result is registered before it is offered.
// Throughput one byte per cycle while the result sink keeps up, set by the single result register stage.
// rst_n (async, active low) clears the config, frame state and result valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module datagram_deframe_check
    import ddc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int KEY_MAX_BYTES   = DEF_KEY_MAX_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    ddc_rx_if.sink            rx,
    ddc_res_if.source         res
);

    // The configuration block holds the magic word, the two halves of the
    // XOR key and the key length. Writes are registered and take effect on
    // the very next beat, which is what lets key changes act at once.
    cfg_t cfg;

    // A beat is taken from the receive channel whenever the result register
    // is empty or is being drained this cycle. Beats that produce no result
    // (magic and checksum bytes, bytes of a frame with a bad magic) still
    // move the frame state forward, so the input never waits on them.
    logic rx_fire;
    logic eng_has_result;
    logic out_in_ready;
    res_t eng_res;
    res_t held_res;

    assign rx_fire  = rx.valid && out_in_ready;
    assign rx.ready = out_in_ready;

    ddc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The engine does all per-byte work in one pass: magic compare on the
    // first two bytes, key XOR and checksum capture on the next two, and the
    // two modulo-255 accumulators on payload bytes. On the last byte it picks
    // the frame status and returns every frame register to zero.
    ddc_frame_engine #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .KEY_MAX_BYTES   (KEY_MAX_BYTES)
    ) u_frame_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .beat_fire  (rx_fire),
        .rx_byte    (rx.rx_byte),
        .rx_last    (rx.rx_last),
        .res        (eng_res),
        .has_result (eng_has_result)
    );

    // The result register separates the two channels: a finished result waits
    // there for the sink, and the next byte is taken only as it leaves.
    ddc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (eng_has_result),
        .res_in    (eng_res),
        .out_ready (res.ready),
        .out_valid (res.valid),
        .res_out   (held_res),
        .in_ready  (out_in_ready)
    );

    assign res.payload_byte  = held_res.payload_byte;
    assign res.payload_valid = held_res.payload_valid;
    assign res.frame_end     = held_res.frame_end;
    assign res.frame_status  = held_res.frame_status;

endmodule

// File: hw/rtl/ddc_checker.sv
// ----------------------------------------------------------------------------
// ddc_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "datagram_deframe_check_macros.svh"

module ddc_checker
    import ddc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] payload_byte,
    input logic       payload_valid,
    input logic       frame_end,
    input logic [2:0] frame_status
);

    // A stalled result keeps its contents.
    `DDC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable({payload_byte, payload_valid, frame_end, frame_status}))

    // Every result carries a payload byte, closes a frame, or both.
    `DDC_ASSERT_IMPLY(a_res_nonempty, clk, rst_n, res_valid, payload_valid || frame_end)

    // Status is only reported on the closing result of a frame.
    `DDC_ASSERT_IMPLY(a_status_end, clk, rst_n, res_valid && !frame_end, frame_status == ST_OK)

    // Payload byte reads as zero when it carries nothing.
    `DDC_ASSERT_IMPLY(a_payload_zero, clk, rst_n, res_valid && !payload_valid, payload_byte == 8'd0)

    // With no result held, the receive side must be open.
    `DDC_ASSERT_IMPLY(a_rx_open, clk, rst_n, !res_valid, rx_ready)

endmodule

bind datagram_deframe_check ddc_checker u_ddc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_ready      (rx.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .payload_byte  (res.payload_byte),
    .payload_valid (res.payload_valid),
    .frame_end     (res.frame_end),
    .frame_status  (res.frame_status)
);

// File: sim/datagram_deframe_check_test.sv
// ----------------------------------------------------------------------------
// Datagram deframer testbench
// Drives received datagrams through the byte channel and programs marker and
// key over the register port. A scoreboard predicts every result beat and
// compares it with what the block emits, under random pacing on both sides.
// ----------------------------------------------------------------------------
module datagram_deframe_check_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ddc_pkg::*;

    localparam int FRAME_LIMIT   = DEF_MAX_FRAME_BYTES;
    localparam int KEY_LIMIT     = DEF_KEY_MAX_BYTES;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 7;
    localparam int PHASE_BEATS   = 55;

    // How a generated datagram is damaged, if at all.
    typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_MARKER, FR_NOISE} frame_kind_t;

    // Pacing patterns for the result channel.
    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MASK} stall_mode_t;

    // The scoreboard keeps its own copy of the registers and of the frame
    // state, works out the result beat (if any) of every accepted byte, and
    // matches emitted results against the oldest outstanding prediction.
    class frame_tracker;
        logic [15:0] magic;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [4:0]  key_len;
        int          pos_count;
        int          key_idx;
        int          fl_a;
        int          fl_b;
        logic [7:0]  marker_hi;
        logic [15:0] sum_rx;
        bit          marker_ok;
        res_t        due_results[$];
        int          failures;

        function new();
            magic    = '0;
            key_lo   = '0;
            key_hi   = '0;
            key_len  = '0;
            failures = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos_count = 0;
            key_idx   = 0;
            fl_a      = 0;
            fl_b      = 0;
            marker_hi = '0;
            sum_rx    = '0;
            marker_ok = 1'b0;
        endfunction

        function void set_register(reg_idx_t idx, logic [63:0] value);
            case (idx)
                REG_MAGIC:      magic   = value[15:0];
                REG_KEY_LOW:    key_lo  = value;
                REG_KEY_HIGH:   key_hi  = value;
                REG_KEY_LENGTH: key_len = value[4:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] key_byte(int idx);
            int k;
            k = idx & 15;
            if (k < 8)
                return key_lo[8*k +: 8];
            return key_hi[8*(k-8) +: 8];
        endfunction

        function void take_byte(logic [7:0] value, logic last);
            int         pos;
            int         count;
            int         klen;
            logic [7:0] d;
            res_t       r;
            status_t    st;
            pos   = pos_count;
            count = (pos + 1 > FRAME_LIMIT + 1) ? FRAME_LIMIT + 1 : pos + 1;
            klen  = (key_len > KEY_LIMIT) ? KEY_LIMIT : int'(key_len);
            r     = '0;
            st    = ST_OK;
            if (pos == 0)
            begin
                marker_hi = value;
            end
            else if (pos == 1)
            begin
                marker_ok = ({marker_hi, value} == magic);
            end
            else if (pos < FRAME_LIMIT)
            begin
                d = value;
                if (klen != 0)
                begin
                    d = d ^ key_byte(key_idx);
                    key_idx = (key_idx + 1 >= klen) ? 0 : key_idx + 1;
                end
                if (pos == 2)
                begin
                    sum_rx[15:8] = d;
                end
                else if (pos == 3)
                begin
                    sum_rx[7:0] = d;
                end
                else if (marker_ok)
                begin
                    fl_a = (fl_a + d) % 255;
                    fl_b = (fl_b + fl_a) % 255;
                    r.payload_valid = 1'b1;
                    r.payload_byte  = d;
                end
            end
            pos_count = count;
            if (last)
            begin
                if (count < 2)
                    st = ST_SHORT_HEADER;
                else if (count > FRAME_LIMIT)
                    st = ST_TOO_LONG;
                else if (!marker_ok)
                    st = ST_BAD_MAGIC;
                else if (count == 2)
                    st = ST_KEEPALIVE;
                else if (count < 4)
                    st = ST_SHORT_SUM;
                else if ({8'(fl_b), 8'(fl_a)} != sum_rx)
                    st = ST_SUM_MISMATCH;
                r.frame_end    = 1'b1;
                r.frame_status = st;
                clear_frame();
            end
            if (r.payload_valid || last)
                due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void match_result(logic [7:0] pbyte, logic pvalid, logic fend,
                                   logic [2:0] fstat);
            res_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: byte %0h valid %0b end %0b status %0d",
                         $time, pbyte, pvalid, fend, fstat);
                failures++;
                return;
            end
            want = due_results.pop_front();
            compare_field("payload_byte", want.payload_byte, pbyte);
            compare_field("payload_valid", 8'(want.payload_valid), 8'(pvalid));
            compare_field("frame_end", 8'(want.frame_end), 8'(fend));
            compare_field("frame_status", 8'(want.frame_status), 8'(fstat));
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic              clk = 1'b1;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ddc_rx_if  byte_ch();
    ddc_res_if result_ch();

    frame_tracker tracker;

    // Datagram under construction: body is the plaintext payload, dgram the
    // bytes as they go on the wire.
    logic [7:0] body[$];
    logic [7:0] dgram[$];

    int burst_left  = 0;
    int sent_beats  = 0;
    int idle_cycles = 0;
    bit offering    = 1'b0;
    bit hold_request = 1'b0;

    datagram_deframe_check i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (byte_ch),
        .res     (result_ch)
    );

    // 8 ns clock period.
    always
    begin
        #4 clk = 1'b0;
        #4 clk = 1'b1;
    end

    // Register write. The caller lowers psel once its last write is done, so
    // back-to-back writes go straight from one access phase to the next setup.
    task automatic apb_write(reg_idx_t idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << REG_ADDR_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_register(idx, value);
    endtask

    // Stop offering bytes and wait until every predicted result has come
    // out. It never returns before a clock edge, so valid is never lowered
    // and raised again within the same time step.
    task automatic wait_for_results();
        if (offering)
        begin
            byte_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        burst_left = 0;
        do @(posedge clk); while (tracker.outstanding() != 0);
    endtask

    // Registers are only written while the block is idle. A byte that makes
    // no result may still be in flight when the last result arrives, so the
    // block is left to settle before the writes. Phase 0 is the directed setting;
    // phases 1 to 5 walk through the extremes of the marker, key and key length; the rest are random.
    task automatic load_settings(int phase);
        logic [15:0] m;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  kl;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        m  = 16'($urandom);
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        kl = 5'($urandom_range(0, 31));
        case (phase)
            0:
            begin
                m  = 16'hA55A;
                lo = 64'h0123_4567_89AB_CDEF;
                hi = 64'hFEDC_BA98_7654_3210;
                kl = 5'd3;
            end
            1:
            begin
                m  = 16'h0000;
                lo = '0;
                hi = '0;
                kl = 5'd0;
            end
            2:
            begin
                m  = 16'hFFFF;
                lo = '1;
                hi = '1;
                kl = 5'd16;
            end
            3: kl = 5'd31;
            4: kl = 5'd1;
            5: kl = 5'd17;
            default: ;
        endcase
        apb_write(REG_MAGIC, 64'(m));
        apb_write(REG_KEY_LOW, lo);
        apb_write(REG_KEY_HIGH, hi);
        apb_write(REG_KEY_LENGTH, 64'(kl));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic void fill_body(int n);
        body.delete();
        repeat (n) body.push_back(8'($urandom));
    endfunction

    // Builds a wire image from body with the current marker and key: the
    // marker in clear, then the checksum and payload under the repeating key.
    // A nonzero cut_len truncates the image to that many bytes.
    function automatic void build_datagram(frame_kind_t kind, int cut_len);
        logic [15:0] mark;
        logic [15:0] chk;
        logic [7:0]  plain[$];
        int          s1;
        int          s2;
        int          k;
        int          klen;
        dgram.delete();
        if (kind == FR_NOISE)
        begin
            dgram = body;
        end
        else
        begin
            s1 = 0;
            s2 = 0;
            foreach (body[i])
            begin
                s1 = (s1 + body[i]) % 255;
                s2 = (s2 + s1) % 255;
            end
            chk = {8'(s2), 8'(s1)};
            if (kind == FR_BAD_SUM)
                chk = chk ^ 16'($urandom_range(1, 65535));
            mark = tracker.magic;
            if (kind == FR_BAD_MARKER)
                mark = mark ^ 16'($urandom_range(1, 65535));
            plain.push_back(chk[15:8]);
            plain.push_back(chk[7:0]);
            foreach (body[i])
                plain.push_back(body[i]);
            klen = (tracker.key_len > KEY_LIMIT) ? KEY_LIMIT : int'(tracker.key_len);
            dgram.push_back(mark[15:8]);
            dgram.push_back(mark[7:0]);
            k = 0;
            foreach (plain[i])
            begin
                if (klen == 0)
                begin
                    dgram.push_back(plain[i]);
                end
                else
                begin
                    dgram.push_back(plain[i] ^ tracker.key_byte(k));
                    k = (k + 1) % klen;
                end
            end
        end
        if (cut_len > 0)
        begin
            while (dgram.size() > cut_len)
                void'(dgram.pop_back());
        end
    endfunction

    // Offers one byte and waits for the beat to be taken. The sender works
    // in bursts; between bursts it may drop valid.
    task automatic push_byte(logic [7:0] value, logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                if (offering)
                begin
                    byte_ch.valid <= 1'b0;
                    offering = 1'b0;
                end
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
        end
        burst_left--;
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= value;
        byte_ch.rx_last <= last;
        offering = 1'b1;
        do @(posedge clk); while (!byte_ch.ready);
        tracker.take_byte(value, last);
    endtask

    task automatic send_datagram();
        foreach (dgram[i])
            push_byte(dgram[i], i == dgram.size() - 1);
        sent_beats += dgram.size();
    endtask

    // Most random datagrams are well formed with random payload, so the
    // payload path and the checksum compare get real exercise; the rest are
    // damaged checksums, wrong markers, truncated headers and plain noise.
    task automatic send_random_datagram();
        int roll;
        int len;
        roll = $urandom_range(0, 99);
        len  = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        fill_body(len);
        if (roll < 60)
            build_datagram(FR_GOOD, 0);
        else if (roll < 70)
            build_datagram(FR_BAD_SUM, 0);
        else if (roll < 78)
            build_datagram(FR_BAD_MARKER, 0);
        else if (roll < 85)
            build_datagram(FR_GOOD, $urandom_range(1, 4));
        else
        begin
            fill_body($urandom_range(1, 8));
            build_datagram(FR_NOISE, 0);
        end
        send_datagram();
    endtask

    // One datagram per frame status except too long, plus an empty payload
    // and the byte extremes.
    task automatic run_directed();
        body.delete();
        build_datagram(FR_GOOD, 1);         // a lone byte: short header
        send_datagram();
        build_datagram(FR_GOOD, 2);         // marker only: keepalive
        send_datagram();
        build_datagram(FR_GOOD, 3);         // half a checksum
        send_datagram();
        body = '{8'h7F};
        build_datagram(FR_BAD_MARKER, 0);
        send_datagram();
        body = '{8'h00, 8'hFF};
        build_datagram(FR_GOOD, 0);
        send_datagram();
        body = '{8'h80};
        build_datagram(FR_BAD_SUM, 0);
        send_datagram();
        body.delete();
        build_datagram(FR_GOOD, 0);         // header with an empty payload
        send_datagram();
        body = '{8'hFF};
        build_datagram(FR_NOISE, 0);
        send_datagram();
    endtask

    // Result channel pacing. Each pattern lasts a random stretch; on request
    // the channel is held off for a long time while the sender keeps going,
    // which fills the block and stalls its input.
    initial
    begin : result_pacing
        int          mode_left;
        stall_mode_t mode;
        logic [7:0]  mask;
        mode_left = 0;
        mode      = RX_ALWAYS;
        mask      = 8'b1011_0010;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS: result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        mask = {mask[6:0], mask[7]};
                        result_ch.ready <= mask[0];
                    end
                endcase
            end
        end
    end

    // Every result beat taken is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tracker.match_result(result_ch.payload_byte, result_ch.payload_valid,
                                 result_ch.frame_end, result_ch.frame_status);
    end

    // Watchdog: too long without a beat on either channel means the block
    // is stuck or has lost a result.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int phase_start;
        int frames;
        tracker = new();
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= '0;
        byte_ch.rx_last <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(0);
        run_directed();

        for (int phase = 1; phase <= PHASES; phase++)
        begin
            load_settings(phase);
            // Long hold-off on the result side while bytes keep coming.
            if (phase == 2)
                hold_request = 1'b1;
            phase_start = sent_beats;
            frames      = 0;
            while (sent_beats - phase_start < PHASE_BEATS)
            begin
                send_random_datagram();
                frames++;
                // The sender pauses until the block has drained completely.
                if (phase == 4 && frames == 3)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (tracker.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ddc_pkg.sv
hw/rtl/ddc_stream_if.sv
hw/rtl/ddc_cfg_regs.sv
hw/rtl/ddc_frame_engine.sv
hw/rtl/ddc_out_reg.sv
hw/rtl/datagram_deframe_check.sv
hw/rtl/ddc_checker.sv
sim/datagram_deframe_check_test.sv
